FILE: src/morton_direct_mapped_height_cache_defines.svh
// Assertion macros for the height cache RTL.
`ifndef MORTON_DIRECT_MAPPED_HEIGHT_CACHE_DEFINES_SVH
`define MORTON_DIRECT_MAPPED_HEIGHT_CACHE_DEFINES_SVH

`ifndef SYNTH
// Clocked check that is switched off while reset is asserted.
`define MDHC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("height cache check failed");
// Clocked check that stays active through reset.
`define MDHC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("height cache reset check failed");
`else
`define MDHC_ASSERT(lbl, prop)
`define MDHC_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: src/mdhc_pkg.sv
package mdhc_pkg;

  localparam longint CACHE_SIDE = 128;
  localparam int     SIDE_W     = $clog2(CACHE_SIDE);
  localparam longint DEPTH      = CACHE_SIDE * CACHE_SIDE;
  localparam int     ADDR_W     = $clog2(DEPTH);
  localparam int     IDX_W      = 2 * SIDE_W;

  localparam int COORD_W  = 16;
  localparam int HEIGHT_W = 32;
  localparam int ENTRY_W  = HEIGHT_W + 2 * COORD_W;

  localparam logic [SIDE_W-1:0] SIDE_MASK = SIDE_W'(CACHE_SIDE - 1);
  localparam logic [IDX_W+1:0]  DEPTH_V   = (IDX_W + 2)'(DEPTH);
  localparam logic [IDX_W+1:0]  DEPTH_X2  = (IDX_W + 2)'(2 * DEPTH);

  // One cache line: height word on top, then the y tag, x tag lowest.
  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [COORD_W-1:0]  ytag;
    logic [COORD_W-1:0]  xtag;
  } entry_t;

  typedef enum logic {
    CLR_SWEEP,
    CLR_DONE
  } clr_state_t;

  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] addr;
  } clr_t;

  // Interleave the masked low coordinate bits, x in even positions and y in
  // odd ones, then wrap into the table depth. The wrap only matters when the
  // side is not a power of two; the interleaved value is always below four
  // times the depth, so two conditional subtractions are enough.
  function automatic logic [ADDR_W-1:0] morton_index(logic [COORD_W-1:0] x,
                                                     logic [COORD_W-1:0] y);
    logic [SIDE_W-1:0] xm;
    logic [SIDE_W-1:0] ym;
    logic [IDX_W+1:0]  v;
    xm = x[SIDE_W-1:0] & SIDE_MASK;
    ym = y[SIDE_W-1:0] & SIDE_MASK;
    v  = '0;
    for (int i = 0; i < SIDE_W; i++) begin
      v[2*i]   = xm[i];
      v[2*i+1] = ym[i];
    end
    if (v >= DEPTH_X2) begin
      v = v - DEPTH_X2;
    end
    if (v >= DEPTH_V) begin
      v = v - DEPTH_V;
    end
    return v[ADDR_W-1:0];
  endfunction

endpackage

FILE: src/mdhc_ram.sv
module mdhc_ram #(
  parameter  int     WIDTH  = 64,
  parameter  longint DEPTH  = 1024,
  localparam int     ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/mdhc_clear.sv
module mdhc_clear (
  input  logic          clk,
  input  logic          rst_n,
  output mdhc_pkg::clr_t clr
);

  mdhc_pkg::clr_state_t      state_r;
  mdhc_pkg::clr_state_t      state_nxt;
  logic [mdhc_pkg::ADDR_W-1:0] cnt_r;
  logic [mdhc_pkg::ADDR_W-1:0] cnt_nxt;
  logic                        last;

  assign last = (cnt_r == mdhc_pkg::ADDR_W'(mdhc_pkg::DEPTH - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mdhc_pkg::CLR_SWEEP: begin
        if (last) begin
          state_nxt = mdhc_pkg::CLR_DONE;
        end
      end
      mdhc_pkg::CLR_DONE: begin
        state_nxt = mdhc_pkg::CLR_DONE;
      end
      default: begin
        state_nxt = mdhc_pkg::CLR_SWEEP;
      end
    endcase
  end

  always_comb begin
    clr.busy = 1'b0;
    clr.addr = cnt_r;
    cnt_nxt  = cnt_r;
    unique case (state_r)
      mdhc_pkg::CLR_SWEEP: begin
        clr.busy = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
      end
      mdhc_pkg::CLR_DONE: begin
        clr.busy = 1'b0;
      end
      default: begin
        clr.busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdhc_pkg::CLR_SWEEP;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: src/morton_direct_mapped_height_cache.sv
// Channel | Dir | Ports                         | Word contents (low bit up)
// --------+-----+-------------------------------+-----------------------------------
// in      | in  | in_tvalid in_tready in_tdata  | x_coord, y_coord, fetched_height
// out     | out | out_tvalid out_tready out_*   | tdata: height_word; tuser: hit
//
// One word is accepted per cycle while in_tready is high. An accepted request
// has its table read registered in the lookup stage, then gets the tag compare
// and refill write on its way into the output register. The single table read
// port and write port set that rate. After reset the table is swept to zero,
// one entry per cycle, across all DEPTH (16384) entries, with in_tready held low.
// A stalled result holds in the output register, the lookup stage behind it too;
// after the sweep, in_tready drops only when both are full and out_tready is low.

`include "morton_direct_mapped_height_cache_defines.svh"

module morton_direct_mapped_height_cache (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // x_coord[15:0], y_coord[31:16], fetched_height[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // height_word[31:0]
  output logic        out_tuser   // hit
);

  localparam int AW = mdhc_pkg::ADDR_W;
  localparam int CW = mdhc_pkg::COORD_W;
  localparam int HW = mdhc_pkg::HEIGHT_W;

  mdhc_pkg::clr_t clr;

  logic                in_accept;
  logic [CW-1:0]       in_x;
  logic [CW-1:0]       in_y;
  logic [HW-1:0]       in_fetch;
  logic [AW-1:0]       in_idx;

  // Lookup stage: holds the request whose table read is in flight.
  logic                s1_valid_r, s1_valid_nxt;
  logic [CW-1:0]       s1_x_r;
  logic [CW-1:0]       s1_y_r;
  logic [HW-1:0]       s1_fetch_r;
  logic [AW-1:0]       s1_idx_r;
  logic                s1_fwd_r;
  mdhc_pkg::entry_t    s1_fwd_data_r;
  logic                s1_go;
  logic                s1_hit;
  logic                s1_wr;
  mdhc_pkg::entry_t    s1_entry;
  mdhc_pkg::entry_t    s1_new;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [HW-1:0]       out_height_r;
  logic                out_hit_r;

  // Table port signals.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  mdhc_pkg::entry_t    ram_wdata;
  mdhc_pkg::entry_t    ram_rdata;

  mdhc_clear u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr)
  );

  mdhc_ram #(
    .WIDTH (mdhc_pkg::ENTRY_W),
    .DEPTH (mdhc_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  assign in_x     = in_tdata[15:0];
  assign in_y     = in_tdata[31:16];
  assign in_fetch = in_tdata[63:32];
  assign in_idx   = mdhc_pkg::morton_index(in_x, in_y);

  // The lookup stage moves on whenever the output register is free or drains.
  assign s1_go     = !out_valid_r || out_tready;
  assign in_tready = !clr.busy && (!s1_valid_r || s1_go);
  assign in_accept = in_tvalid && in_tready;

  // A refill written in the same cycle as the next read of that entry is not
  // yet visible in the read data, so the written line is carried along.
  assign s1_entry = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign s1_hit   = (s1_entry.xtag == s1_x_r) && (s1_entry.ytag == s1_y_r);
  assign s1_wr    = s1_valid_r && s1_go && !s1_hit;

  always_comb begin
    s1_new.height = s1_fetch_r;
    s1_new.ytag   = s1_y_r;
    s1_new.xtag   = s1_x_r;
  end

  // The clearing sweep owns the write port; no request is in flight then.
  assign ram_we    = clr.busy || s1_wr;
  assign ram_waddr = clr.busy ? clr.addr : s1_idx_r;
  assign ram_wdata = clr.busy ? '0 : s1_new;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_valid_r && s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_x_r        <= in_x;
      s1_y_r        <= in_y;
      s1_fetch_r    <= in_fetch;
      s1_idx_r      <= in_idx;
      s1_fwd_r      <= s1_wr && (s1_idx_r == in_idx);
      s1_fwd_data_r <= s1_new;
    end
    if (s1_valid_r && s1_go) begin
      out_height_r <= s1_hit ? s1_entry.height : s1_fetch_r;
      out_hit_r    <= s1_hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_height_r;
  assign out_tuser  = out_hit_r;

  // An accepted word always occupies the lookup stage in the next cycle.
  `MDHC_ASSERT(a_accept_fills_stage, in_accept |=> s1_valid_r)
  // The sweep writes zero lines and never overlaps a request.
  `MDHC_ASSERT(a_sweep_clean, clr.busy |-> (ram_we && ram_wdata == '0 && !s1_valid_r))
  // Only a miss rewrites its line.
  `MDHC_ASSERT(a_write_on_miss, (ram_we && !clr.busy) |-> (s1_valid_r && !s1_hit))
  // Nothing is offered right after reset.
  `MDHC_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid)

endmodule

FILE: sim/morton_direct_mapped_height_cache_tb.sv
`timescale 1ns / 1ps

// Mirror of the height cache: keeps its own copy of every line and queues the
// reply that each accepted lookup word must produce.
typedef struct packed {
  logic [31:0] height;
  logic        hit;
} height_reply_t;

class height_cache_mirror;
  logic [15:0]   line_xtag   [int'(mdhc_pkg::DEPTH)];
  logic [15:0]   line_ytag   [int'(mdhc_pkg::DEPTH)];
  logic [31:0]   line_height [int'(mdhc_pkg::DEPTH)];
  height_reply_t pending_replies[$];
  int            mismatches;

  function new();
    foreach (line_xtag[i]) begin
      line_xtag[i]   = '0;
      line_ytag[i]   = '0;
      line_height[i] = '0;
    end
    mismatches = 0;
  endfunction

  // Low coordinate bits interleaved, x on even bits and y on odd bits, then
  // wrapped into the table.
  function int unsigned line_of(logic [15:0] x, logic [15:0] y);
    int unsigned side_mask;
    int unsigned xm;
    int unsigned ym;
    int unsigned idx;
    side_mask = int'(mdhc_pkg::CACHE_SIDE) - 1;
    xm        = x & side_mask;
    ym        = y & side_mask;
    idx       = 0;
    for (int b = 0; b < 16; b++) begin
      idx |= ((xm >> b) & 1) << (2 * b);
      idx |= ((ym >> b) & 1) << (2 * b + 1);
    end
    return idx % int'(mdhc_pkg::DEPTH);
  endfunction

  function void note_lookup(logic [63:0] word);
    logic [15:0]   x;
    logic [15:0]   y;
    logic [31:0]   fetched;
    int unsigned   idx;
    height_reply_t reply;
    x       = word[15:0];
    y       = word[31:16];
    fetched = word[63:32];
    idx     = line_of(x, y);
    if (line_xtag[idx] == x && line_ytag[idx] == y) begin
      reply.height = line_height[idx];
      reply.hit    = 1'b1;
    end else begin
      line_xtag[idx]   = x;
      line_ytag[idx]   = y;
      line_height[idx] = fetched;
      reply.height     = fetched;
      reply.hit        = 1'b0;
    end
    pending_replies.push_back(reply);
  endfunction

  function void check_reply(logic [31:0] height, logic hit);
    height_reply_t want;
    if (pending_replies.size() == 0) begin
      $display("%0t: unexpected result height_word=%h hit=%b", $time, height, hit);
      mismatches++;
      return;
    end
    want = pending_replies.pop_front();
    if (height !== want.height) begin
      $display("%0t: height_word mismatch, expected %h, actual %h",
               $time, want.height, height);
      mismatches++;
    end
    if (hit !== want.hit) begin
      $display("%0t: hit mismatch, expected %b, actual %b", $time, want.hit, hit);
      mismatches++;
    end
  endfunction
endclass

module morton_direct_mapped_height_cache_tb;

  // The sweep after reset clears one table line per cycle with nothing
  // accepted, so the watchdog limit sits well above the table depth.
  localparam int          WATCHDOG_LIMIT = 100000;
  localparam int          RANDOM_PER_PHASE = 600;
  localparam int          POOL_MAX = 48;
  localparam logic [15:0] LOW_MASK = 16'(mdhc_pkg::CACHE_SIDE - 1);

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // x_coord[15:0], y_coord[31:16], fetched_height[63:32]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // height_word[31:0]
  logic        out_tuser;  // hit

  height_cache_mirror board;

  // Idle percentages for both sides; the top-level sequence changes them
  // between phases.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  // Coordinates requested recently, packed as {y, x}. Reusing them produces
  // hits, and perturbing their upper bits produces aliasing evictions.
  logic [31:0] recent_coords[$];

  morton_direct_mapped_height_cache u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // The receiver decides at every falling edge whether it takes a word at the
  // next rising edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // All handshakes are sampled at the rising edge, before the block's own
  // registers update in that time step. A lookup is noted before the result
  // of the same edge is checked; the block's latency keeps them apart anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        board.note_lookup(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        board.check_reply(out_tdata, out_tuser);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offers one lookup word. It is entered at a falling edge and returns at the
  // falling edge after the word was accepted, with in_tvalid still high so a
  // following word continues without a gap.
  task automatic send_lookup(input logic [15:0] x, input logic [15:0] y,
                             input logic [31:0] fetched);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {fetched, y, x};
    do begin
      @(posedge clk);
    end while (!in_tready);
    @(negedge clk);
  endtask

  // Holds the input idle until every queued reply has come back.
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (board.pending_replies.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Random lookups shaped like a terrain walker: mostly revisits and nearby
  // tiles, some aliases that share a line with a recent tile, and some fully
  // random coordinates so every bit of both coordinates toggles.
  task automatic walk_terrain(input int count);
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] fetched;
    logic [31:0] base;
    int unsigned mode;
    bit          revisit;
    for (int n = 0; n < count; n++) begin
      mode    = $urandom_range(99);
      revisit = 1'b0;
      base    = $urandom;
      if (recent_coords.size() != 0) begin
        base = recent_coords[$urandom_range(recent_coords.size() - 1)];
      end
      x = base[15:0];
      y = base[31:16];
      if (mode < 45 && recent_coords.size() != 0) begin
        revisit = 1'b1;
      end else if (mode < 65) begin
        // Same line, different tag: the upper bits change, the low bits stay.
        x = (16'($urandom) & ~LOW_MASK) | (x & LOW_MASK);
        if ($urandom_range(1)) begin
          y = (16'($urandom) & ~LOW_MASK) | (y & LOW_MASK);
        end
      end else if (mode < 80) begin
        x = x + 16'($urandom_range(2)) - 16'd1;
        y = y + 16'($urandom_range(2)) - 16'd1;
      end else begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      case ($urandom_range(9))
        0: fetched = '0;
        1: fetched = '1;
        default: fetched = $urandom;
      endcase
      if (!revisit) begin
        recent_coords.push_back({y, x});
        if (recent_coords.size() > POOL_MAX) begin
          void'(recent_coords.pop_front());
        end
      end
      send_lookup(x, y, fetched);
    end
  endtask

  initial begin
    board         = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    quiet_cycles  = 0;
    send_idle_pct = 15;
    recv_idle_pct = 51;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A cleared line holds tags (0,0), so the origin hits with height zero
    // and the supplied height is ignored.
    send_lookup(16'd0, 16'd0, 32'h1234_5678);
    send_lookup(16'd0, 16'd0, 32'hffff_ffff);
    // Ordinary miss and refill, then a hit that ignores the new height.
    send_lookup(16'd1, 16'd0, 32'hffff_ffff);
    send_lookup(16'd1, 16'd0, 32'h0000_0000);
    send_lookup(16'd0, 16'd1, 32'ha5a5_a5a5);
    // The most negative pair aliases the origin line and evicts it; the origin
    // then misses and refills.
    send_lookup(16'h8000, 16'h8000, 32'h0000_0000);
    send_lookup(16'd0, 16'd0, 32'h5a5a_5a5a);
    send_lookup(16'd0, 16'd0, 32'h0000_0000);
    // The last line of the table reached from three tag pairs in turn,
    // negative ones among them.
    send_lookup(16'h7fff, 16'h7fff, 32'hdead_beef);
    send_lookup(16'hffff, 16'hffff, 32'h0000_0001);
    send_lookup(16'hffff, 16'hffff, 32'h0000_0002);
    send_lookup(16'h7fff, 16'h7fff, 32'h0000_0003);
    send_lookup(16'h007f, 16'hff7f, 32'h8000_0000);
    send_lookup(16'h007f, 16'hff7f, 32'h7fff_ffff);
    // Low bits only in y, then only in x.
    send_lookup(16'h8000, 16'h7fff, 32'h0f0f_0f0f);
    send_lookup(16'h8000, 16'h7fff, 32'hf0f0_f0f0);
    send_lookup(16'h7fff, 16'h8000, 32'h3333_3333);
    send_lookup(16'h7fff, 16'h8000, 32'hcccc_cccc);
    // Back-to-back refill and reuse of one line across the pipeline.
    send_lookup(16'h0155, 16'h02aa, 32'h5555_5555);
    send_lookup(16'h0155, 16'h02aa, 32'haaaa_aaaa);
    send_lookup(16'h0355, 16'h02aa, 32'h1111_1111);
    send_lookup(16'h0155, 16'h02aa, 32'h2222_2222);

    walk_terrain(RANDOM_PER_PHASE);

    // The sender holds off until the block has returned everything.
    drain_replies();
    send_idle_pct = 51;
    recv_idle_pct = 15;
    walk_terrain(RANDOM_PER_PHASE);

    drain_replies();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    walk_terrain(RANDOM_PER_PHASE);

    in_tvalid <= 1'b0;
    while (board.pending_replies.size() != 0) begin
      @(posedge clk);
    end
    // A further wait after the last reply shows up any stray word.
    repeat (8) @(posedge clk);

    if (board.mismatches == 0 && board.pending_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
